// ===== sv/bfwal_pkg.sv =====
// bfwal_pkg: shared types, codes and constants of the boolean function walsh / affine unit
// no dependencies; used by every module of the block except bfwal_table

package bfwal_pkg;

    localparam int MAX_VARS_DEF = 10;

    localparam int IDX_W   = 10;
    localparam int POINT_W = 10;
    localparam int WALSH_W = 12;
    localparam int COEF_W  = 10;
    localparam int NV_W    = 4;

    localparam logic [NV_W-1:0] NUM_VARS_RST = 4'd10;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_WALSH  = 2'd1,
        MODE_AFFINE = 2'd2
    } mode_e;

    typedef struct packed {
        logic [1:0]         mode;
        logic [IDX_W-1:0]   table_index;
        logic               table_bit;
        logic [POINT_W-1:0] spectrum_point;
    } item_t;

    typedef struct packed {
        logic signed [WALSH_W-1:0] walsh_value;
        logic                      is_affine;
        logic [COEF_W-1:0]         linear_coeffs;
        logic                      constant_term;
    } result_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_ZERO,
        SEQ_PROBE,
        SEQ_SCAN,
        SEQ_DRAIN,
        SEQ_DONE
    } seq_state_e;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_PROBE,
        KIND_SCAN
    } read_kind_e;

    typedef struct packed {
        logic       valid;
        read_kind_e kind;
    } read_tag_t;

    typedef struct packed {
        logic start;
        logic walsh;
    } cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_status_t;

endpackage

// ===== sv/bfwal_table.sv =====
// bfwal_table: truth table memory, one bit per entry, one write and one registered read port
// depends on nothing but its parameter

module bfwal_table #(
    parameter int MAX_VARS = 10
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [MAX_VARS-1:0] wr_addr,
    input  logic                wr_bit,
    input  logic                rd_en,
    input  logic [MAX_VARS-1:0] rd_addr,
    output logic                rd_bit
);

    localparam int DEPTH = 1 << MAX_VARS;

    logic mem_reg [DEPTH];
    logic rd_bit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_bit_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

// ===== sv/bfwal_seq.sv =====
// bfwal_seq: sequencer that walks the truth table one entry per cycle
// depends on bfwal_pkg; drives the read port of bfwal_table and tags each read

module bfwal_seq #(
    parameter int MAX_VARS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfwal_pkg::cmd_t               cmd,
    input  logic [bfwal_pkg::NV_W-1:0]    num_vars,
    input  logic                          done_ack,
    output bfwal_pkg::seq_status_t        status,
    output logic                          rd_en,
    output logic [MAX_VARS-1:0]           rd_addr,
    output bfwal_pkg::read_tag_t          tag,
    output logic [MAX_VARS-1:0]           tag_addr
);

    localparam int NW = $clog2(MAX_VARS + 1);
    localparam int WW = NW + bfwal_pkg::NV_W;

    bfwal_pkg::seq_state_e state_reg, state_next;
    logic [MAX_VARS-1:0]   cnt_reg, cnt_next;
    logic [MAX_VARS-1:0]   probe_reg, probe_next;
    bfwal_pkg::read_tag_t  tag_reg;
    logic [MAX_VARS-1:0]   tag_addr_reg;
    bfwal_pkg::read_kind_e kind;

    logic [WW-1:0]         nv_wide;
    logic [NW-1:0]         n_eff;
    logic [MAX_VARS-1:0]   last_y;
    logic                  probe_last;
    logic                  scan_last;

    // effective variable count, clamped to 1..MAX_VARS
    always_comb
    begin
        nv_wide = {{NW{1'b0}}, num_vars};
        if (num_vars == '0)
        begin
            n_eff = NW'(1);
        end
        else if (nv_wide > WW'(MAX_VARS))
        begin
            n_eff = NW'(MAX_VARS);
        end
        else
        begin
            n_eff = nv_wide[NW-1:0];
        end
    end

    assign last_y     = ~({MAX_VARS{1'b1}} << n_eff);
    assign probe_last = |({probe_reg, 1'b0} & ~{1'b0, last_y});
    assign scan_last  = (cnt_reg == last_y);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfwal_pkg::SEQ_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = cmd.walsh ? bfwal_pkg::SEQ_SCAN : bfwal_pkg::SEQ_ZERO;
                end
            end
            bfwal_pkg::SEQ_ZERO:
            begin
                state_next = bfwal_pkg::SEQ_PROBE;
            end
            bfwal_pkg::SEQ_PROBE:
            begin
                if (probe_last)
                begin
                    state_next = bfwal_pkg::SEQ_SCAN;
                end
            end
            bfwal_pkg::SEQ_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = bfwal_pkg::SEQ_DRAIN;
                end
            end
            bfwal_pkg::SEQ_DRAIN:
            begin
                state_next = bfwal_pkg::SEQ_DONE;
            end
            bfwal_pkg::SEQ_DONE:
            begin
                if (done_ack)
                begin
                    state_next = bfwal_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = bfwal_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr     = '0;
        kind        = bfwal_pkg::KIND_SCAN;
        status.idle = 1'b0;
        status.done = 1'b0;
        case (state_reg)
            bfwal_pkg::SEQ_IDLE:
            begin
                status.idle = 1'b1;
            end
            bfwal_pkg::SEQ_ZERO:
            begin
                rd_en = 1'b1;
                kind  = bfwal_pkg::KIND_ZERO;
            end
            bfwal_pkg::SEQ_PROBE:
            begin
                rd_en   = 1'b1;
                rd_addr = probe_reg;
                kind    = bfwal_pkg::KIND_PROBE;
            end
            bfwal_pkg::SEQ_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = cnt_reg;
            end
            bfwal_pkg::SEQ_DONE:
            begin
                status.done = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next   = (state_reg == bfwal_pkg::SEQ_SCAN) ? cnt_reg + MAX_VARS'(1) : '0;
        probe_next = (state_reg == bfwal_pkg::SEQ_PROBE) ? (probe_reg << 1) : MAX_VARS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfwal_pkg::SEQ_IDLE;
            tag_reg.valid <= 1'b0;
            tag_reg.kind  <= bfwal_pkg::KIND_SCAN;
        end
        else
        begin
            state_reg     <= state_next;
            tag_reg.valid <= rd_en;
            tag_reg.kind  <= kind;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        probe_reg    <= probe_next;
        tag_addr_reg <= rd_addr;
    end

    assign tag      = tag_reg;
    assign tag_addr = tag_addr_reg;

    a_tag_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg.valid |-> $past(rd_en))
        else $error("read tag without a read in the previous cycle");

    a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfwal_pkg::SEQ_DRAIN) |-> ($past(state_reg) == bfwal_pkg::SEQ_SCAN))
        else $error("drain not entered from scan");

endmodule

// ===== sv/bfwal_accum.sv =====
// bfwal_accum: serial datapath taking one table bit per cycle into the walsh sum or affine check
// depends on bfwal_pkg; fed by bfwal_seq tags and bfwal_table read data

module bfwal_accum #(
    parameter int MAX_VARS = 10
) (
    input  logic                 clk,
    input  bfwal_pkg::cmd_t      cmd,
    input  logic [MAX_VARS-1:0]  point,
    input  bfwal_pkg::read_tag_t tag,
    input  logic [MAX_VARS-1:0]  tag_addr,
    input  logic                 rd_bit,
    output bfwal_pkg::result_t   res
);

    localparam int WV = bfwal_pkg::WALSH_W;
    localparam int CW = bfwal_pkg::COEF_W;

    logic                walsh_reg, walsh_next;
    logic [MAX_VARS-1:0] x_reg, x_next;
    logic [WV-1:0]       acc_reg, acc_next;
    logic                mism_reg, mism_next;
    logic [MAX_VARS-1:0] w_reg, w_next;
    logic                c_reg, c_next;

    logic                par_x;
    logic                par_w;
    logic [CW+MAX_VARS-1:0] w_wide;

    assign par_x = ^(x_reg & tag_addr);
    assign par_w = ^(w_reg & tag_addr);

    always_comb
    begin
        walsh_next = walsh_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        mism_next  = mism_reg;
        w_next     = w_reg;
        c_next     = c_reg;
        if (cmd.start)
        begin
            walsh_next = cmd.walsh;
            x_next     = point;
            acc_next   = '0;
            mism_next  = 1'b0;
        end
        else if (tag.valid)
        begin
            case (tag.kind)
                bfwal_pkg::KIND_ZERO:
                begin
                    c_next = rd_bit;
                    w_next = '0;
                end
                bfwal_pkg::KIND_PROBE:
                begin
                    if (rd_bit ^ c_reg)
                    begin
                        w_next = w_reg | tag_addr;
                    end
                end
                bfwal_pkg::KIND_SCAN:
                begin
                    if (walsh_reg)
                    begin
                        acc_next = (rd_bit ^ par_x) ? acc_reg - WV'(1) : acc_reg + WV'(1);
                    end
                    else
                    begin
                        mism_next = mism_reg | (rd_bit ^ par_w ^ c_reg);
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        walsh_reg <= walsh_next;
        x_reg     <= x_next;
        acc_reg   <= acc_next;
        mism_reg  <= mism_next;
        w_reg     <= w_next;
        c_reg     <= c_next;
    end

    assign w_wide = {{CW{1'b0}}, w_reg};

    always_comb
    begin
        if (walsh_reg)
        begin
            res.walsh_value   = acc_reg;
            res.is_affine     = 1'b0;
            res.linear_coeffs = '0;
            res.constant_term = 1'b0;
        end
        else
        begin
            res.walsh_value   = '0;
            res.is_affine     = ~mism_reg;
            res.linear_coeffs = mism_reg ? '0 : w_wide[CW-1:0];
            res.constant_term = c_reg;
        end
    end

endmodule

// ===== sv/boolean_function_walsh_affine_unit.sv =====
// boolean_function_walsh_affine_unit: top level, handshakes, config register and result register
// depends on bfwal_pkg, bfwal_table, bfwal_seq and bfwal_accum
//
// channel   direction  handshake             payload
// item      in         item_valid/item_stall item (bfwal_pkg::item_t)
// res       out        res_valid/res_stall   res (bfwal_pkg::result_t)
// cfg       in         cfg_valid/cfg_ready   cfg_data (num_vars)
//
// a load leaves the sequencer idle; the next item may follow at once
// a walsh query reads 2^n entries, an affine test 1 + n + 2^n; one table read per cycle
// item_stall stays high while a query walks the table and until its result enters the
// result register; a load is taken while a result still waits there
// reset clears control state and sets num_vars to 10; the table holds no reset value

module boolean_function_walsh_affine_unit #(
    parameter int MAX_VARS = bfwal_pkg::MAX_VARS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  bfwal_pkg::item_t              item,
    output logic                          res_valid,
    input  logic                          res_stall,
    output bfwal_pkg::result_t            res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfwal_pkg::NV_W-1:0]    cfg_data
);

    localparam int IW = bfwal_pkg::IDX_W;
    localparam int PW = bfwal_pkg::POINT_W;

    logic [bfwal_pkg::NV_W-1:0] num_vars_reg, num_vars_next;
    logic                       res_valid_reg, res_valid_next;
    bfwal_pkg::result_t         res_reg;

    logic                       accept;
    logic                       out_free;
    logic                       done_fire;
    bfwal_pkg::cmd_t            cmd;
    bfwal_pkg::seq_status_t     status;
    logic                       wr_en;
    logic [IW+MAX_VARS-1:0]     idx_wide;
    logic [PW+MAX_VARS-1:0]     point_wide;
    logic                       rd_en;
    logic [MAX_VARS-1:0]        rd_addr;
    logic                       rd_bit;
    bfwal_pkg::read_tag_t       tag;
    logic [MAX_VARS-1:0]        tag_addr;
    bfwal_pkg::result_t         acc_res;

    assign cfg_ready  = 1'b1;
    assign item_stall = ~status.idle;
    assign accept     = item_valid & ~item_stall;

    assign cmd.start = accept & ((item.mode == bfwal_pkg::MODE_WALSH) ||
                                 (item.mode == bfwal_pkg::MODE_AFFINE));
    assign cmd.walsh = (item.mode == bfwal_pkg::MODE_WALSH);
    assign wr_en     = accept & (item.mode == bfwal_pkg::MODE_LOAD);

    assign idx_wide   = {{MAX_VARS{1'b0}}, item.table_index};
    assign point_wide = {{MAX_VARS{1'b0}}, item.spectrum_point};

    assign out_free  = ~res_valid_reg | ~res_stall;
    assign done_fire = status.done & out_free;

    always_comb
    begin
        num_vars_next = (cfg_valid & cfg_ready) ? cfg_data : num_vars_reg;
        if (done_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (~res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vars_reg  <= bfwal_pkg::NUM_VARS_RST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            num_vars_reg  <= num_vars_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            res_reg <= acc_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    bfwal_table #(
        .MAX_VARS (MAX_VARS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_wide[MAX_VARS-1:0]),
        .wr_bit  (item.table_bit),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_bit  (rd_bit)
    );

    bfwal_seq #(
        .MAX_VARS (MAX_VARS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .num_vars (num_vars_reg),
        .done_ack (out_free),
        .status   (status),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .tag      (tag),
        .tag_addr (tag_addr)
    );

    bfwal_accum #(
        .MAX_VARS (MAX_VARS)
    ) u_accum (
        .clk      (clk),
        .cmd      (cmd),
        .point    (point_wide[MAX_VARS-1:0]),
        .tag      (tag),
        .tag_addr (tag_addr),
        .rd_bit   (rd_bit),
        .res      (acc_res)
    );

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(done_fire))
        else $error("result appeared without a finished query");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.mode == bfwal_pkg::MODE_LOAD)) |=> status.idle)
        else $error("load item started the sequencer");

endmodule

// ===== sim/walsh_affine_checker.sv =====
`timescale 1ns / 1ps
// walsh_affine_checker: watches the item, result and config channels of the walsh / affine unit,
// predicts every result from its own copy of the truth table and num_vars, and counts mismatches
// depends on bfwal_pkg

module walsh_affine_checker
    import bfwal_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  item_t            item,
    input  logic             res_valid,
    input  logic             res_stall,
    input  result_t          res,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [NV_W-1:0]  cfg_data,
    output int               mismatches,
    output int               outstanding
);

    logic            fn_table [1024];
    logic [NV_W-1:0] vars_reg;
    result_t         expected_q [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        vars_reg    = NUM_VARS_RST;
        foreach (fn_table[i])
            fn_table[i] = 1'b0;
    end

    function automatic int active_vars();
        int n;
        n = vars_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_VARS_DEF)
            n = MAX_VARS_DEF;
        return n;
    endfunction

    function automatic result_t walsh_coefficient(logic [POINT_W-1:0] x);
        result_t r;
        int      sum;
        sum = 0;
        for (int y = 0; y < (1 << active_vars()); y++)
        begin
            if (fn_table[y] ^ (^(x & y[POINT_W-1:0])))
                sum--;
            else
                sum++;
        end
        r = '0;
        r.walsh_value = sum[WALSH_W-1:0];
        return r;
    endfunction

    function automatic result_t affine_decomposition();
        result_t          r;
        logic [COEF_W-1:0] w;
        logic             c;
        logic             affine;
        int               n;
        n      = active_vars();
        c      = fn_table[0];
        w      = '0;
        affine = 1'b1;
        for (int i = 0; i < n; i++)
            w[i] = fn_table[1 << i] ^ c;
        for (int y = 0; y < (1 << n); y++)
        begin
            if (fn_table[y] !== ((^(w & y[COEF_W-1:0])) ^ c))
                affine = 1'b0;
        end
        r = '0;
        r.is_affine     = affine;
        r.linear_coeffs = affine ? w : '0;
        r.constant_term = c;
        return r;
    endfunction

    task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            vars_reg = NUM_VARS_RST;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                vars_reg = cfg_data;
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no item waiting, walsh_value %0d",
                                 $realtime, res.walsh_value);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("walsh_value", want.walsh_value, res.walsh_value);
                    check_field("is_affine", want.is_affine, res.is_affine);
                    check_field("linear_coeffs", want.linear_coeffs, res.linear_coeffs);
                    check_field("constant_term", want.constant_term, res.constant_term);
                end
            end
            if (item_valid && !item_stall)
            begin
                case (item.mode)
                    MODE_LOAD:
                        fn_table[item.table_index] = item.table_bit;
                    MODE_WALSH:
                        expected_q.push_back(walsh_coefficient(item.spectrum_point));
                    MODE_AFFINE:
                        expected_q.push_back(affine_decomposition());
                    default: ;
                endcase
            end
        end
        outstanding = expected_q.size();
    end

endmodule

// ===== sim/tb_boolean_function_walsh_affine_unit.sv =====
`timescale 1ns / 1ps
// tb_boolean_function_walsh_affine_unit: stimulus and verdict for the walsh / affine unit
// depends on bfwal_pkg, boolean_function_walsh_affine_unit and walsh_affine_checker

module tb_boolean_function_walsh_affine_unit;

    import bfwal_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         ITEM_TARGET  = 580;
    localparam int         FINAL_ITEMS  = 280;

    localparam int FN_RANDOM   = 0;
    localparam int FN_AFFINE   = 1;
    localparam int FN_NEAR     = 2;
    localparam int FN_CONSTANT = 3;
    localparam int FN_SPARSE   = 4;

    logic            clk;
    logic            rst_n;
    logic            item_valid;
    logic            item_stall;
    item_t           item;
    logic            res_valid;
    logic            res_stall;
    result_t         res;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [NV_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int cycle_count;
    int items_sent;
    int active_n;
    bit item_bursts;
    bit stall_bursts;
    bit hold_pending;

    boolean_function_walsh_affine_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    walsh_affine_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
        cycle_count = 0;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_boolean_function_walsh_affine_unit NOT OK");
        $finish;
    end

    // result side: stall bursts, free stretches and one long hold-off
    initial
    begin
        res_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_bursts && $urandom_range(0, 3) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                res_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    function automatic item_t make_item(logic [1:0] m, int idx, bit b, int pt);
        item_t it;
        it.mode           = m;
        it.table_index    = idx[IDX_W-1:0];
        it.table_bit      = b;
        it.spectrum_point = pt[POINT_W-1:0];
        return it;
    endfunction

    task automatic offer(input item_t it);
        if (item_bursts && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (it.mode != MODE_UNUSED)
            items_sent++;
    endtask

    task automatic load_bit(int idx, bit b);
        offer(make_item(MODE_LOAD, idx, b, $urandom));
    endtask

    task automatic walsh_query(int pt);
        offer(make_item(MODE_WALSH, $urandom, $urandom, pt));
    endtask

    task automatic affine_test();
        offer(make_item(MODE_AFFINE, $urandom, $urandom, $urandom));
    endtask

    // wait until every result is back and the block is quiet
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_vars(logic [NV_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        active_n = (v == 0) ? 1 : (v > MAX_VARS_DEF) ? MAX_VARS_DEF : int'(v);
    endtask

    // fills entries 0 .. 2^n-1 with a function of the given shape, now and then also an entry above
    task automatic load_table(int shape);
        int               size;
        int               flip_at;
        logic [COEF_W-1:0] w;
        bit               c;
        bit               b;
        size    = 1 << active_n;
        flip_at = $urandom_range(0, size - 1);
        w       = $urandom;
        c       = $urandom;
        for (int y = 0; y < size; y++)
        begin
            case (shape)
                FN_AFFINE:   b = (^(w & y[COEF_W-1:0])) ^ c;
                FN_NEAR:     b = (^(w & y[COEF_W-1:0])) ^ c ^ (y == flip_at);
                FN_CONSTANT: b = c;
                FN_SPARSE:   b = c ^ ($urandom_range(0, 7) == 0);
                default:     b = $urandom;
            endcase
            load_bit(y, b);
            if (size < 1024 && $urandom_range(0, 15) == 0)
                load_bit(size + $urandom_range(0, 1023 - size), $urandom);
        end
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(0, 19);
        if (r <= 8)
            walsh_query($urandom);
        else if (r <= 14)
            affine_test();
        else if (r <= 16)
            load_bit($urandom_range(0, (1 << active_n) - 1), $urandom);
        else if (r == 17)
            load_bit($urandom, $urandom);
        else
            offer(make_item(MODE_UNUSED, $urandom, $urandom, $urandom));
    endtask

    initial
    begin
        logic [NV_W-1:0] v;
        bit              pressure_done;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        items_sent    = 0;
        active_n      = MAX_VARS_DEF;
        item_bursts   = 1'b1;
        stall_bursts  = 1'b1;
        hold_pending  = 1'b0;
        pressure_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed: num_vars 0 runs as one variable
        write_vars(4'd0);
        load_bit(0, 1'b0);
        load_bit(1, 1'b1);
        walsh_query(0);
        walsh_query(1);
        walsh_query(10'h3FF);
        affine_test();
        offer(make_item(MODE_UNUSED, 10'h3FF, 1'b1, 10'h3FF));
        load_bit(10'h3FF, 1'b1);
        load_bit(0, 1'b1);
        affine_test();
        walsh_query(0);
        settle();
        write_vars(4'd2);
        load_bit(2, 1'b1);
        load_bit(3, 1'b0);
        affine_test();
        walsh_query(3);
        walsh_query(2);
        load_bit(3, 1'b1);
        affine_test();
        walsh_query(0);

        // random phases, small tables
        while (items_sent < ITEM_TARGET - FINAL_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 9))
                0:       v = 4'd0;
                default: v = $urandom_range(1, 6);
            endcase
            write_vars(v);
            repeat (3)
            begin
                load_table($urandom_range(FN_RANDOM, FN_SPARSE));
                repeat ($urandom_range(2, 6))
                    random_step();
            end
            if (!pressure_done && items_sent > 200)
            begin
                pressure_done = 1'b1;
                hold_pending  = 1'b1;
                repeat (6)
                begin
                    walsh_query($urandom);
                    load_bit($urandom_range(0, (1 << active_n) - 1), $urandom);
                end
            end
        end

        // largest table of the run (num_vars 8), no idling on either side
        item_bursts  = 1'b0;
        stall_bursts = 1'b0;
        settle();
        write_vars(4'd8);
        load_table(FN_AFFINE);
        walsh_query(10'h3FF);
        walsh_query($urandom);
        affine_test();
        load_bit($urandom_range(0, (1 << active_n) - 1), $urandom);
        affine_test();
        walsh_query(0);

        item_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_boolean_function_walsh_affine_unit OK");
        else
            $display("tb_boolean_function_walsh_affine_unit NOT OK");
        $finish;
    end

endmodule
